// ----- rtl/core/dnba_pkg.sv -----
// ----------------------------------------------------------------------------
// dnba_pkg
// Shared types and constants of the device number bitmap allocator.
// ----------------------------------------------------------------------------
package dnba_pkg;

  localparam int unsigned TableEntries = 8;
  localparam int unsigned NumIds       = 256;
  localparam int unsigned WordW        = 64;
  localparam int unsigned NumWords     = NumIds / WordW;
  localparam int unsigned WordIdxW     = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned EntIdxW      = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned BitIdxW      = $clog2(WordW);
  localparam int unsigned MemDepth     = 2 * TableEntries * NumWords;
  localparam int unsigned MemAddrW     = $clog2(MemDepth);

  typedef enum logic [1:0] {
    OP_ALLOC_MAJOR = 2'd0,
    OP_FREE_MAJOR  = 2'd1,
    OP_ALLOC_DEV   = 2'd2,
    OP_FREE_DEV    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NONE_FREE   = 3'd1,
    ST_ALREADY     = 3'd2,
    ST_NOT_IN_TAB  = 3'd3,
    ST_NULL_DEV    = 3'd4,
    ST_UNUSED5     = 3'd5,
    ST_UNUSED6     = 3'd6,
    ST_UNUSED7     = 3'd7
  } status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic       is_char;
    logic [7:0] major_in;
    logic [7:0] minor_in;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] major_out;
    logic [7:0] minor_out;
  } rsp_t;

  function automatic logic [NumIds-1:0] reset_mask(input logic pool);
    logic [255:0] m;
    if (pool) begin
      m = {64'hffff007f3f0fffff, 64'hffffffff7cffffff,
           64'hffffffffffffffff, 64'hfffffffffffffeff};
    end else begin
      m = {64'hffff000000000280, 64'h0000000000000000,
           64'hff03ffeffffffffe, 64'hfffffffffffffb8f};
    end
    return m[NumIds-1:0];
  endfunction

endpackage

// ----- rtl/core/dnba_if.sv -----
// ----------------------------------------------------------------------------
// dnba_req_if / dnba_rsp_if
// Valid/ready channels that carry requests and responses.
// ----------------------------------------------------------------------------
interface dnba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       is_char;
  logic [7:0] major_in;
  logic [7:0] minor_in;
  modport source (output valid, opcode, is_char, major_in, minor_in, input ready);
  modport sink (input valid, opcode, is_char, major_in, minor_in, output ready);
endinterface

interface dnba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] major_out;
  logic [7:0] minor_out;
  modport source (output valid, status, major_out, minor_out, input ready);
  modport sink (input valid, status, major_out, minor_out, output ready);
endinterface

// ----- rtl/core/dnba_front.sv -----
// ----------------------------------------------------------------------------
// dnba_front
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dnba_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  dnba_req_if.sink          req,
  output logic              q_valid_o,
  output dnba_pkg::req_t    q_data_o,
  input  logic              q_pop_i
);
  import dnba_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{opcode: req.opcode, is_char: req.is_char,
                       major_in: req.major_in, minor_in: req.minor_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ----- rtl/core/dnba_back.sv -----
// ----------------------------------------------------------------------------
// dnba_back
// Executes one request at a time: scans the minor-map memory one 64-bit word
// at a time, reading and then checking each, and drives a registered response.
// ----------------------------------------------------------------------------
module dnba_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  dnba_pkg::req_t    q_data_i,
  output logic              q_pop_o,
  dnba_rsp_if.source        rsp
);
  import dnba_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DEC    = 8'b0000_0010,
    S_RD     = 8'b0000_0100,
    S_CHK    = 8'b0000_1000,
    S_NEWMAJ = 8'b0001_0000,
    S_CLR    = 8'b0010_0000,
    S_FRD    = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [NumIds-1:0]     major_q [2];
  logic [7:0]            emaj_q [2][TableEntries];
  logic [CntW-1:0]       ecnt_q [2];
  logic                  exh_q [2];
  logic [WordW-1:0]      mem [MemDepth];
  logic [WordW-1:0]      rdata_q;
  req_t                  req_q;
  logic [EntIdxW-1:0]    ent_q;
  logic [WordIdxW-1:0]   wrd_q;
  logic [2:0]            st_q;
  logic [7:0]            mo_q, no_q;
  logic                  hit_q;
  logic [EntIdxW-1:0]    hent_q;
  logic                  rvalid_q;

  logic                  we;
  logic [MemAddrW-1:0]   waddr, raddr;
  logic [WordW-1:0]      wdata;
  logic                  re;

  function automatic logic [MemAddrW-1:0] addr_of(input logic p,
      input logic [EntIdxW-1:0] e, input logic [WordIdxW-1:0] w);
    logic [31:0] a;
    a = (32'(p) * TableEntries + 32'(e)) * NumWords + 32'(w);
    return a[MemAddrW-1:0];
  endfunction

  function automatic logic [8:0] first_zero(input logic [NumIds-1:0] v);
    logic [8:0] r;
    r = 9'(NumIds);
    for (int i = NumIds - 1; i >= 0; i--) begin
      if (!v[i]) r = 9'(i);
    end
    return r;
  endfunction

  function automatic logic [BitIdxW:0] fz64(input logic [WordW-1:0] v);
    logic [BitIdxW:0] r;
    r = (BitIdxW+1)'(WordW);
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!v[i]) r = (BitIdxW+1)'(i);
    end
    return r;
  endfunction

  logic              p;
  logic [8:0]        mfz;
  logic [BitIdxW:0]  wfz;
  logic              match_any;
  logic [EntIdxW-1:0] match_idx;
  logic [WordIdxW-1:0] mword;
  logic [BitIdxW-1:0]  mbit;

  assign p     = req_q.is_char;
  assign mfz   = first_zero(major_q[p]);
  assign wfz   = fz64(rdata_q);
  assign mword = req_q.minor_in[7:BitIdxW];
  assign mbit  = req_q.minor_in[BitIdxW-1:0];

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int e = TableEntries - 1; e >= 0; e--) begin
      if ((CntW'(e) < ecnt_q[p]) && (emaj_q[p][e] == req_q.major_in)) begin
        match_any = 1'b1;
        match_idx = EntIdxW'(e);
      end
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i && !rvalid_q;
  assign rsp.valid     = rvalid_q;
  assign rsp.status    = st_q;
  assign rsp.major_out = mo_q;
  assign rsp.minor_out = no_q;

  always_comb begin
    we    = 1'b0;
    waddr = addr_of(p, ent_q, wrd_q);
    wdata = rdata_q;
    re    = 1'b0;
    raddr = addr_of(p, ent_q, wrd_q);
    unique case (state_q)
      S_RD:  re = 1'b1;
      S_FRD: begin
        re = 1'b1;
        raddr = addr_of(p, hent_q, mword);
      end
      S_CHK: begin
        if (wfz != (BitIdxW+1)'(WordW)) begin
          we = 1'b1;
          wdata = rdata_q | (WordW'(1) << wfz[BitIdxW-1:0]);
        end
      end
      S_CLR: begin
        we = 1'b1;
        wdata = (wrd_q == '0) ? WordW'(1) : '0;
      end
      S_RESP: begin
        if (hit_q) begin
          we = 1'b1;
          waddr = addr_of(p, hent_q, mword);
          wdata = rdata_q & ~(WordW'(1) << mbit);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_data_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (q_pop_o) state_d = S_DEC;
      S_DEC:    state_d = S_RESP;
      S_RD:     state_d = S_CHK;
      S_CHK:    state_d = S_RESP;
      S_NEWMAJ: state_d = S_CLR;
      S_CLR:    state_d = S_RESP;
      S_FRD:    state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if (state_q == S_DEC && req_q.opcode == OP_ALLOC_DEV && !exh_q[p]) begin
      state_d = (ecnt_q[p] != '0) ? S_RD : S_NEWMAJ;
    end
    if (state_q == S_DEC && req_q.opcode == OP_FREE_DEV && match_any &&
        !(req_q.major_in == 8'd0 && req_q.minor_in == 8'd0) &&
        (req_q.minor_in < 9'(NumIds))) begin
      state_d = S_FRD;
    end
    if (state_q == S_CHK && wfz == (BitIdxW+1)'(WordW)) begin
      if (wrd_q != WordIdxW'(NumWords - 1)) state_d = S_RD;
      else if (CntW'(ent_q) + 1'b1 < ecnt_q[p]) state_d = S_RD;
      else state_d = S_NEWMAJ;
    end
    if (state_q == S_NEWMAJ &&
        (ecnt_q[p] >= CntW'(TableEntries) || mfz >= 9'(NumIds))) begin
      state_d = S_RESP;
    end
    if (state_q == S_CLR && wrd_q != WordIdxW'(NumWords - 1)) state_d = S_CLR;
    if (state_q == S_RESP && rvalid_q && !rsp.ready) state_d = S_RESP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      major_q[0] <= reset_mask(1'b0);
      major_q[1] <= reset_mask(1'b1);
      ecnt_q[0] <= '0;
      ecnt_q[1] <= '0;
      exh_q[0]  <= 1'b0;
      exh_q[1]  <= 1'b0;
      rvalid_q <= 1'b0;
      ent_q <= '0; wrd_q <= '0; st_q <= '0; mo_q <= '0; no_q <= '0;
      hit_q <= 1'b0; hent_q <= '0;
    end else begin
      state_q <= state_d;
      if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            ent_q <= '0; wrd_q <= '0; hit_q <= 1'b0;
            st_q <= ST_OK; mo_q <= '0; no_q <= '0;
          end
        end
        S_DEC: begin
          unique case (op_e'(req_q.opcode))
            OP_ALLOC_MAJOR: begin
              if (mfz >= 9'(NumIds)) st_q <= ST_NONE_FREE;
              else begin
                major_q[p][mfz[7:0]] <= 1'b1;
                mo_q <= mfz[7:0];
              end
            end
            OP_FREE_MAJOR: begin
              if (!major_q[p][req_q.major_in]) st_q <= ST_ALREADY;
              else major_q[p][req_q.major_in] <= 1'b0;
            end
            OP_ALLOC_DEV: if (exh_q[p]) st_q <= ST_NONE_FREE;
            OP_FREE_DEV: begin
              hent_q <= match_idx;
              if (req_q.major_in == 8'd0 && req_q.minor_in == 8'd0) st_q <= ST_NULL_DEV;
              else if (!match_any) st_q <= ST_NOT_IN_TAB;
              else if (!(req_q.minor_in < 9'(NumIds))) st_q <= ST_ALREADY;
            end
            default: ;
          endcase
        end
        S_CHK: begin
          if (wfz != (BitIdxW+1)'(WordW)) begin
            mo_q <= emaj_q[p][ent_q];
            no_q <= 8'({wrd_q, wfz[BitIdxW-1:0]});
          end else if (wrd_q != WordIdxW'(NumWords - 1)) begin
            wrd_q <= wrd_q + 1'b1;
          end else begin
            wrd_q <= '0;
            if (CntW'(ent_q) + 1'b1 < ecnt_q[p]) ent_q <= ent_q + 1'b1;
          end
        end
        S_NEWMAJ: begin
          if (ecnt_q[p] >= CntW'(TableEntries) || mfz >= 9'(NumIds)) begin
            exh_q[p] <= 1'b1;
            st_q <= ST_NONE_FREE;
          end else begin
            major_q[p][mfz[7:0]] <= 1'b1;
            ent_q  <= EntIdxW'(ecnt_q[p]);
            wrd_q  <= '0;
            emaj_q[p][EntIdxW'(ecnt_q[p])] <= mfz[7:0];
            ecnt_q[p] <= ecnt_q[p] + 1'b1;
            mo_q <= mfz[7:0];
            no_q <= '0;
          end
        end
        S_CLR: wrd_q <= wrd_q + 1'b1;
        S_FRD: hit_q <= 1'b1;
        S_RESP: begin
          if (hit_q) begin
            hit_q <= 1'b0;
            if (!rdata_q[mbit]) st_q <= ST_ALREADY;
            else exh_q[p] <= 1'b0;
          end
          if (!rvalid_q) rvalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/device_number_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// device_number_bitmap_allocator
// Two-pool major/minor device number allocator with a request queue.
// ----------------------------------------------------------------------------
// A device allocation may scan all 32 minor words of a full table.
// Throughput: one request at a time; the next one starts the cycle after the
// response transfer, so the minor-map word scan sets the rate.
// Reset: asynchronous; major maps load the preassigned masks, tables empty.
module device_number_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  dnba_req_if.sink    req,
  dnba_rsp_if.source  rsp
);
  import dnba_pkg::*;

  logic q_valid, q_pop;
  req_t q_data;

  dnba_front u_front (
    .clk_i, .rst_ni, .req,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  dnba_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .rsp
  );

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.status <= ST_NULL_DEV)) else $error("bad status");
  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.minor_out == 8'd0))
    else $error("minor out on failure");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status) &&
    $stable(rsp.major_out) && $stable(rsp.minor_out)))
    else $error("response changed while waiting");

endmodule

// ----- tb/dnba_checker.sv -----
// ----------------------------------------------------------------------------
// dnba_checker
// Watches the request and response channels of the device number allocator.
// It keeps its own copy of both pools, works out the response to every
// accepted request and compares each response transfer with the oldest
// expected one.
// ----------------------------------------------------------------------------
module dnba_checker
  import dnba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dnba_req_if         req,
  dnba_rsp_if         rsp,
  output int unsigned fail_cnt_o,
  output int unsigned pend_o
);

  localparam int Slots = 8;

  logic [255:0] major_map [2];
  logic [255:0] minor_map [2][Slots];
  logic [7:0]   slot_major [2][Slots];
  int           slot_cnt [2];
  bit           pool_dry [2];
  rsp_t         grants_q [$];

  function automatic int lowest_clear(input logic [255:0] m);
    for (int i = 0; i < 256; i++) begin
      if (!m[i]) return i;
    end
    return 256;
  endfunction

  function automatic rsp_t grant(input req_t r);
    rsp_t o;
    int   p;
    int   n;
    int   cnt;
    bit   done;
    o = '0;
    o.status = ST_OK;
    p = r.is_char;
    case (op_e'(r.opcode))
      OP_ALLOC_MAJOR: begin
        n = lowest_clear(major_map[p]);
        if (n >= 256) begin
          o.status = ST_NONE_FREE;
        end else begin
          major_map[p][n] = 1'b1;
          o.major_out = n[7:0];
        end
      end
      OP_FREE_MAJOR: begin
        if (!major_map[p][r.major_in]) o.status = ST_ALREADY;
        else major_map[p][r.major_in] = 1'b0;
      end
      OP_ALLOC_DEV: begin
        if (pool_dry[p]) begin
          o.status = ST_NONE_FREE;
        end else begin
          done = 0;
          cnt = slot_cnt[p];
          for (int e = 0; e < cnt; e++) begin
            n = lowest_clear(minor_map[p][e]);
            if (n < 256) begin
              minor_map[p][e][n] = 1'b1;
              o.major_out = slot_major[p][e];
              o.minor_out = n[7:0];
              done = 1;
              break;
            end
          end
          if (!done) begin
            n = lowest_clear(major_map[p]);
            if (cnt >= Slots || n >= 256) begin
              pool_dry[p] = 1;
              o.status = ST_NONE_FREE;
            end else begin
              major_map[p][n] = 1'b1;
              minor_map[p][cnt] = 256'd1;
              slot_major[p][cnt] = n[7:0];
              slot_cnt[p] = cnt + 1;
              o.major_out = n[7:0];
            end
          end
        end
      end
      default: begin
        if (r.major_in == 0 && r.minor_in == 0) begin
          o.status = ST_NULL_DEV;
        end else begin
          o.status = ST_NOT_IN_TAB;
          for (int e = 0; e < slot_cnt[p]; e++) begin
            if (slot_major[p][e] == r.major_in) begin
              if (minor_map[p][e][r.minor_in]) begin
                minor_map[p][e][r.minor_in] = 1'b0;
                pool_dry[p] = 0;
                o.status = ST_OK;
              end else begin
                o.status = ST_ALREADY;
              end
              break;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t r;
    rsp_t exp_r;
    if (!rst_ni) begin
      major_map[0] = {64'hffff000000000280, 64'h0000000000000000,
                      64'hff03ffeffffffffe, 64'hfffffffffffffb8f};
      major_map[1] = {64'hffff007f3f0fffff, 64'hffffffff7cffffff,
                      64'hffffffffffffffff, 64'hfffffffffffffeff};
      for (int p = 0; p < 2; p++) begin
        slot_cnt[p] = 0;
        pool_dry[p] = 0;
        for (int e = 0; e < Slots; e++) begin
          minor_map[p][e] = '0;
          slot_major[p][e] = '0;
        end
      end
      grants_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (grants_q.size() == 0) begin
          $error("unexpected response transfer: status %0d", rsp.status);
          fail_cnt_o++;
        end else begin
          exp_r = grants_q.pop_front();
          if (rsp.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
            fail_cnt_o++;
          end
          if (rsp.major_out !== exp_r.major_out) begin
            $error("major_out: expected %0d, got %0d", exp_r.major_out, rsp.major_out);
            fail_cnt_o++;
          end
          if (rsp.minor_out !== exp_r.minor_out) begin
            $error("minor_out: expected %0d, got %0d", exp_r.minor_out, rsp.minor_out);
            fail_cnt_o++;
          end
        end
      end
      if (req.valid && req.ready) begin
        r.opcode = req.opcode;
        r.is_char = req.is_char;
        r.major_in = req.major_in;
        r.minor_in = req.minor_in;
        grants_q.push_back(grant(r));
      end
    end
    pend_o = grants_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the device number allocator testbench. It drives directed and
// random requests with random idling on both channels and gives the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
  import dnba_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned sent_cnt;
  int unsigned stall_cnt = 0;

  dnba_req_if req ();
  dnba_rsp_if rsp ();

  device_number_bitmap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  dnba_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .fail_cnt_o (fail_cnt),
    .pend_o     (pend_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send(input op_e op, input logic pool, input logic [7:0] maj,
                      input logic [7:0] mnr);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.opcode = op;
    req.is_char = pool;
    req.major_in = maj;
    req.minor_in = mnr;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_major(input logic pool);
    logic [7:0] near [2][6];
    near[0] = '{8'd4, 8'd5, 8'd6, 8'd10, 8'd64, 8'd68};
    near[1] = '{8'd8, 8'd88, 8'd89, 8'd95, 8'd212, 8'd213};
    if ($urandom_range(3) == 0) return 8'($urandom);
    return near[pool][$urandom_range(5)];
  endfunction

  task automatic random_item();
    op_e        op;
    logic       pool;
    logic [7:0] mnr;
    op = op_e'(2'($urandom_range(3)));
    pool = 1'($urandom_range(1));
    mnr = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    if ($urandom_range(9) < 4) op = OP_ALLOC_DEV;
    send(op, pool, pick_major(pool), mnr);
  endtask

  initial begin
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.opcode = OP_ALLOC_MAJOR;
    req.is_char = 1'b0;
    req.major_in = '0;
    req.minor_in = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    sent_cnt = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(OP_ALLOC_MAJOR, 1'b0, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b0, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b0, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    send(OP_FREE_DEV, 1'b0, 8'd0, 8'd0);
    send(OP_FREE_DEV, 1'b1, 8'd255, 8'd255);
    send(OP_FREE_DEV, 1'b0, 8'd5, 8'd255);
    send(OP_FREE_DEV, 1'b0, 8'd5, 8'd1);
    send(OP_FREE_DEV, 1'b0, 8'd5, 8'd1);
    send(OP_FREE_MAJOR, 1'b0, 8'd255, 8'd0);
    send(OP_FREE_MAJOR, 1'b0, 8'd128, 8'd0);
    send(OP_FREE_MAJOR, 1'b0, 8'd4, 8'd0);
    repeat (18) send(OP_ALLOC_MAJOR, 1'b1, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    send(OP_FREE_DEV, 1'b1, 8'd8, 8'd1);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);

    // Fill the only entry of the character pool, whose major map is already
    // exhausted, so that it reports none free.
    repeat (256) send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    send(OP_FREE_DEV, 1'b1, 8'd8, 8'd5);
    send(OP_ALLOC_DEV, 1'b1, 8'd0, 8'd0);
    drain();

    tx_idle_pct = 26;
    rx_idle_pct = 56;
    repeat (137) random_item();
    drain();
    tx_idle_pct = 56;
    rx_idle_pct = 26;
    repeat (137) random_item();
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (137) random_item();
    drain();
    repeat (100) @(negedge clk_i);

    $display("tb: %0d requests, covering major map exhaustion, a full entry",
             sent_cnt);
    $display("tb: the none-free flag and all free cases under idling");
    if (fail_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
